// ===== src/tbo_pkg.sv =====
// ----------------------------------------------------------------------------
// tbo_pkg
// Shared widths, register indexes and the box record for the overlap test.
// ----------------------------------------------------------------------------
package tbo_pkg;

  localparam int CW  = 24;
  localparam int HW  = 23;
  localparam int IW  = 3;
  localparam int DW  = CW + 2;
  localparam int PW  = 2 * DW + 2;
  localparam int TW  = PW + CW + 4;
  localparam int SH  = 25;

  localparam logic [IW-1:0] REG_CX = 3'd0;
  localparam logic [IW-1:0] REG_CY = 3'd1;
  localparam logic [IW-1:0] REG_CZ = 3'd2;
  localparam logic [IW-1:0] REG_HX = 3'd3;
  localparam logic [IW-1:0] REG_HY = 3'd4;
  localparam logic [IW-1:0] REG_HZ = 3'd5;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [TW-1:0] sum_t;

  typedef struct packed {
    coord_t [2:0] c;
    logic [2:0][HW-1:0] e;
  } box_t;

endpackage

// ===== src/tbo_front.sv =====
// ----------------------------------------------------------------------------
// tbo_front
// Stage one: range rejection, centred vertices and edge vectors.
// ----------------------------------------------------------------------------
module tbo_front import tbo_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic vld_i,
  input  coord_t [2:0][2:0] v_i,
  input  box_t box_i,
  output logic vld_o,
  output logic rej_o,
  output diff_t [2:0][2:0] tv_o,
  output diff_t [2:0][2:0] ed_o,
  output diff_t [2:0] u_o,
  output diff_t [2:0] w_o
);

  logic vld_r;
  logic rej_r, rej_nxt;
  diff_t [2:0][2:0] tv_r, tv_nxt, ed_r, ed_nxt;
  diff_t [2:0] u_r, u_nxt, w_r, w_nxt;

  always_comb begin
    diff_t lo, hi, bmn, bmx, vi;
    rej_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      bmn = DW'(box_i.c[k]) - DW'({1'b0, box_i.e[k]});
      bmx = DW'(box_i.c[k]) + DW'({1'b0, box_i.e[k]});
      lo = DW'(v_i[0][k]);
      hi = lo;
      for (int i = 1; i < 3; i++) begin
        vi = DW'(v_i[i][k]);
        if (vi < lo) lo = vi;
        if (vi > hi) hi = vi;
      end
      if (bmx < lo || hi < bmn) rej_nxt = 1'b1;
      for (int i = 0; i < 3; i++) tv_nxt[i][k] = DW'(v_i[i][k]) - DW'(box_i.c[k]);
      u_nxt[k] = DW'(v_i[1][k]) - DW'(v_i[0][k]);
      w_nxt[k] = DW'(v_i[2][k]) - DW'(v_i[0][k]);
      ed_nxt[0][k] = u_nxt[k];
      ed_nxt[1][k] = DW'(v_i[2][k]) - DW'(v_i[1][k]);
      ed_nxt[2][k] = DW'(v_i[0][k]) - DW'(v_i[2][k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_i;
    rej_r <= rej_nxt;
    tv_r <= tv_nxt;
    ed_r <= ed_nxt;
    u_r <= u_nxt;
    w_r <= w_nxt;
  end

  assign vld_o = vld_r;
  assign rej_o = rej_r;
  assign tv_o = tv_r;
  assign ed_o = ed_r;
  assign u_o = u_r;
  assign w_o = w_r;

endmodule

// ===== src/tbo_prod.sv =====
// ----------------------------------------------------------------------------
// tbo_prod
// Stage two: normal components and edge axis projections.
// ----------------------------------------------------------------------------
module tbo_prod import tbo_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic vld_i,
  input  logic rej_i,
  input  diff_t [2:0][2:0] tv_i,
  input  diff_t [2:0][2:0] ed_i,
  input  diff_t [2:0] u_i,
  input  diff_t [2:0] w_i,
  output logic vld_o,
  output logic rej_o,
  output prod_t [2:0] n_o,
  output diff_t [2:0] tv0_o,
  output prod_t [8:0] p0_o,
  output prod_t [8:0] p1_o,
  output diff_t [8:0][1:0] ax_o
);

  logic vld_r, rej_r;
  prod_t [2:0] n_r, n_nxt;
  diff_t [2:0] tv0_r;
  prod_t [8:0] p0_r, p0_nxt, p1_r, p1_nxt;
  diff_t [8:0][1:0] ax_r, ax_nxt;

  always_comb begin
    int k1, k2, o;
    diff_t a1, a2;
    n_nxt[0] = PW'(u_i[1]) * PW'(w_i[2]) - PW'(u_i[2]) * PW'(w_i[1]);
    n_nxt[1] = PW'(u_i[2]) * PW'(w_i[0]) - PW'(u_i[0]) * PW'(w_i[2]);
    n_nxt[2] = PW'(u_i[0]) * PW'(w_i[1]) - PW'(u_i[1]) * PW'(w_i[0]);
    for (int k = 0; k < 3; k++) begin
      k1 = (k + 1) % 3;
      k2 = (k + 2) % 3;
      for (int j = 0; j < 3; j++) begin
        o = (j == 0) ? 2 : 1;
        a1 = -ed_i[j][k2];
        a2 = ed_i[j][k1];
        p0_nxt[k*3+j] = PW'(tv_i[0][k1]) * PW'(a1) + PW'(tv_i[0][k2]) * PW'(a2);
        p1_nxt[k*3+j] = PW'(tv_i[o][k1]) * PW'(a1) + PW'(tv_i[o][k2]) * PW'(a2);
        ax_nxt[k*3+j][0] = a1;
        ax_nxt[k*3+j][1] = a2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_i;
    rej_r <= rej_i;
    n_r <= n_nxt;
    tv0_r <= tv_i[0];
    p0_r <= p0_nxt;
    p1_r <= p1_nxt;
    ax_r <= ax_nxt;
  end

  assign vld_o = vld_r;
  assign rej_o = rej_r;
  assign n_o = n_r;
  assign tv0_o = tv0_r;
  assign p0_o = p0_r;
  assign p1_o = p1_r;
  assign ax_o = ax_r;

endmodule

// ===== src/tbo_back.sv =====
// ----------------------------------------------------------------------------
// tbo_back
// Stages three and four: radius products, plane test and final decision.
// ----------------------------------------------------------------------------
module tbo_back import tbo_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic vld_i,
  input  logic rej_i,
  input  prod_t [2:0] n_i,
  input  diff_t [2:0] tv0_i,
  input  prod_t [8:0] p0_i,
  input  prod_t [8:0] p1_i,
  input  diff_t [8:0][1:0] ax_i,
  input  box_t box_i,
  output logic vld_o,
  output logic ovl_o,
  output logic deg_o
);

  // plane test uses centred coords: n.(tv0) against +-sum |n_k| e_k
  // normal is split into high and low halves so each product stays narrow
  logic vld3_r, rej3_r, deg3_r, esep3_r;
  prod_t dh3_r, dl3_r, ph3_r, pl3_r;
  logic vld4_r, ovl4_r, deg4_r;
  prod_t dh_nxt, dl_nxt, ph_nxt, pl_nxt;
  sum_t d_full, pr_full;
  logic esep_nxt;

  always_comb begin
    prod_t an, lo, hi, r;
    diff_t b1, b2;
    int k1, k2;
    dh_nxt = '0;
    dl_nxt = '0;
    ph_nxt = '0;
    pl_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      an = n_i[k][PW-1] ? -n_i[k] : n_i[k];
      dh_nxt = dh_nxt + PW'($signed(n_i[k][PW-1:SH])) * PW'(tv0_i[k]);
      dl_nxt = dl_nxt + PW'($signed({1'b0, n_i[k][SH-1:0]})) * PW'(tv0_i[k]);
      ph_nxt = ph_nxt + PW'(an[PW-1:SH]) * PW'({1'b0, box_i.e[k]});
      pl_nxt = pl_nxt + PW'(an[SH-1:0]) * PW'({1'b0, box_i.e[k]});
    end
    esep_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      k1 = (k + 1) % 3;
      k2 = (k + 2) % 3;
      for (int j = 0; j < 3; j++) begin
        b1 = ax_i[k*3+j][0][DW-1] ? -ax_i[k*3+j][0] : ax_i[k*3+j][0];
        b2 = ax_i[k*3+j][1][DW-1] ? -ax_i[k*3+j][1] : ax_i[k*3+j][1];
        r = PW'(b1) * PW'({1'b0, box_i.e[k1]}) + PW'(b2) * PW'({1'b0, box_i.e[k2]});
        lo = (p1_i[k*3+j] < p0_i[k*3+j]) ? p1_i[k*3+j] : p0_i[k*3+j];
        hi = (p1_i[k*3+j] < p0_i[k*3+j]) ? p0_i[k*3+j] : p1_i[k*3+j];
        if (r < lo || hi < -r) esep_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    d_full = (TW'(dh3_r) <<< SH) + TW'(dl3_r);
    pr_full = (TW'(ph3_r) <<< SH) + TW'(pl3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld3_r <= vld_i;
      vld4_r <= vld3_r;
    end
    rej3_r <= rej_i;
    deg3_r <= (n_i == '0);
    esep3_r <= esep_nxt;
    dh3_r <= dh_nxt;
    dl3_r <= dl_nxt;
    ph3_r <= ph_nxt;
    pl3_r <= pl_nxt;
    ovl4_r <= !rej3_r && !deg3_r && !esep3_r && !(pr_full < d_full) && !(d_full < -pr_full);
    deg4_r <= !rej3_r && deg3_r;
  end

  assign vld_o = vld4_r;
  assign ovl_o = ovl4_r;
  assign deg_o = deg4_r;

endmodule

// ===== src/triangle_box_overlap_test.sv =====
// ----------------------------------------------------------------------------
// triangle_box_overlap_test
// Triangle against axis-aligned box overlap test, four-stage pipeline.
// ----------------------------------------------------------------------------
// A triangle is accepted every cycle that start is high (busy stays low); its
// verdict appears after four registers on out_overlap/out_degenerate with
// done high for one cycle. The rate is one test per cycle, set by the fully
// pipelined multiplier stages. Results cannot be held off by the receiver.
module triangle_box_overlap_test import tbo_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  coord_t in_tri_a_x,
  input  coord_t in_tri_a_y,
  input  coord_t in_tri_a_z,
  input  coord_t in_tri_b_x,
  input  coord_t in_tri_b_y,
  input  coord_t in_tri_b_z,
  input  coord_t in_tri_c_x,
  input  coord_t in_tri_c_y,
  input  coord_t in_tri_c_z,
  output logic done,
  output logic out_overlap,
  output logic out_degenerate,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [IW-1:0] cfg_index,
  input  logic [CW-1:0] cfg_data
);

  box_t box_r;
  coord_t [2:0][2:0] v;
  logic v1, r1, v2, r2;
  diff_t [2:0][2:0] tv, ed;
  diff_t [2:0] u, w, tv0;
  prod_t [2:0] n;
  prod_t [8:0] p0, p1;
  diff_t [8:0][1:0] ax;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign v[0] = {in_tri_a_z, in_tri_a_y, in_tri_a_x};
  assign v[1] = {in_tri_b_z, in_tri_b_y, in_tri_b_x};
  assign v[2] = {in_tri_c_z, in_tri_c_y, in_tri_c_x};

  always_ff @(posedge clk) begin
    if (!rst_n) box_r <= '0;
    else if (cfg_valid) begin
      case (cfg_index)
        REG_CX: box_r.c[0] <= cfg_data;
        REG_CY: box_r.c[1] <= cfg_data;
        REG_CZ: box_r.c[2] <= cfg_data;
        REG_HX: box_r.e[0] <= cfg_data[HW-1:0];
        REG_HY: box_r.e[1] <= cfg_data[HW-1:0];
        REG_HZ: box_r.e[2] <= cfg_data[HW-1:0];
        default: ;
      endcase
    end
  end

  tbo_front u_front (.clk(clk), .rst_n(rst_n), .vld_i(start), .v_i(v), .box_i(box_r),
    .vld_o(v1), .rej_o(r1), .tv_o(tv), .ed_o(ed), .u_o(u), .w_o(w));

  tbo_prod u_prod (.clk(clk), .rst_n(rst_n), .vld_i(v1), .rej_i(r1), .tv_i(tv),
    .ed_i(ed), .u_i(u), .w_i(w), .vld_o(v2), .rej_o(r2), .n_o(n), .tv0_o(tv0),
    .p0_o(p0), .p1_o(p1), .ax_o(ax));

  tbo_back u_back (.clk(clk), .rst_n(rst_n), .vld_i(v2), .rej_i(r2), .n_i(n),
    .tv0_i(tv0), .p0_i(p0), .p1_i(p1), .ax_i(ax), .box_i(box_r),
    .vld_o(done), .ovl_o(out_overlap), .deg_o(out_degenerate));

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for triangle_box_overlap_test: triangles go in as
// single-cycle commands, each verdict is compared with an exact wide-integer
// separating-axis computation done here against the current box settings.
// ----------------------------------------------------------------------------
module tb import tbo_pkg::*; ();

  typedef logic signed [127:0] wide_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  coord_t in_tri_a_x, in_tri_a_y, in_tri_a_z;
  coord_t in_tri_b_x, in_tri_b_y, in_tri_b_z;
  coord_t in_tri_c_x, in_tri_c_y, in_tri_c_z;
  logic done;
  logic out_overlap;
  logic out_degenerate;
  logic cfg_valid;
  logic cfg_ready;
  logic [IW-1:0] cfg_index;
  logic [CW-1:0] cfg_data;

  logic [1:0] verdict_q[$];
  logic signed [CW-1:0] box_c[3];
  logic [HW-1:0] box_e[3];
  int errors;
  int gap_pct;

  triangle_box_overlap_test u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_tri_a_x(in_tri_a_x), .in_tri_a_y(in_tri_a_y), .in_tri_a_z(in_tri_a_z),
    .in_tri_b_x(in_tri_b_x), .in_tri_b_y(in_tri_b_y), .in_tri_b_z(in_tri_b_z),
    .in_tri_c_x(in_tri_c_x), .in_tri_c_y(in_tri_c_y), .in_tri_c_z(in_tri_c_z),
    .done(done), .out_overlap(out_overlap), .out_degenerate(out_degenerate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100000000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report(input string what, input logic [1:0] got, input logic [1:0] want);
    errors++;
    $display("mismatch %s: got ovl=%0b deg=%0b want ovl=%0b deg=%0b",
             what, got[1], got[0], want[1], want[0]);
  endtask

  function automatic wide_t wabs(input wide_t x);
    return x < 0 ? -x : x;
  endfunction

  // {overlap, degenerate}
  function automatic logic [1:0] overlap_verdict(input coord_t t[9]);
    wide_t v[3][3], c[3], e[3], bmin[3], bmax[3], tv[3][3], ed[3][3];
    wide_t u[3], w[3], n[3], vmin[3], vmax[3], a[3], d, p0, p1, lo, hi, r;
    int k1, k2;
    logic sep;
    sep = 0;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) v[i][k] = t[i*3+k];
    for (int k = 0; k < 3; k++) begin
      c[k] = box_c[k];
      e[k] = {105'd0, box_e[k]};
      bmin[k] = c[k] - e[k];
      bmax[k] = c[k] + e[k];
    end
    for (int k = 0; k < 3; k++) begin
      lo = v[0][k];
      hi = v[0][k];
      for (int i = 1; i < 3; i++) begin
        if (v[i][k] < lo) lo = v[i][k];
        if (v[i][k] > hi) hi = v[i][k];
      end
      if (bmax[k] < lo || hi < bmin[k]) return 2'b00;
    end
    for (int k = 0; k < 3; k++) begin
      u[k] = v[1][k] - v[0][k];
      w[k] = v[2][k] - v[0][k];
    end
    n[0] = u[1]*w[2] - u[2]*w[1];
    n[1] = u[2]*w[0] - u[0]*w[2];
    n[2] = u[0]*w[1] - u[1]*w[0];
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) return 2'b01;
    d = n[0]*v[0][0] + n[1]*v[0][1] + n[2]*v[0][2];
    for (int k = 0; k < 3; k++) begin
      vmin[k] = n[k] > 0 ? bmin[k] : bmax[k];
      vmax[k] = n[k] > 0 ? bmax[k] : bmin[k];
    end
    if (d < vmin[0]*n[0] + vmin[1]*n[1] + vmin[2]*n[2] ||
        vmax[0]*n[0] + vmax[1]*n[1] + vmax[2]*n[2] < d) sep = 1;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) tv[i][k] = v[i][k] - c[k];
    for (int k = 0; k < 3; k++) begin
      ed[0][k] = tv[1][k] - tv[0][k];
      ed[1][k] = tv[2][k] - tv[1][k];
      ed[2][k] = tv[0][k] - tv[2][k];
    end
    for (int k = 0; k < 3; k++) begin
      k1 = (k + 1) % 3;
      k2 = (k + 2) % 3;
      for (int j = 0; j < 3; j++) begin
        a[k] = 0;
        a[k1] = -ed[j][k2];
        a[k2] = ed[j][k1];
        p0 = tv[0][0]*a[0] + tv[0][1]*a[1] + tv[0][2]*a[2];
        if (j == 0) p1 = tv[2][0]*a[0] + tv[2][1]*a[1] + tv[2][2]*a[2];
        else p1 = tv[1][0]*a[0] + tv[1][1]*a[1] + tv[1][2]*a[2];
        lo = p1 < p0 ? p1 : p0;
        hi = p1 < p0 ? p0 : p1;
        r = e[0]*wabs(a[0]) + e[1]*wabs(a[1]) + e[2]*wabs(a[2]);
        if (r < lo || hi < -r) sep = 1;
      end
    end
    return {~sep, 1'b0};
  endfunction

  always @(posedge clk) begin
    if (rst_n && done) begin
      if (verdict_q.size() == 0) report("unexpected", {out_overlap, out_degenerate}, 2'b00);
      else if ({out_overlap, out_degenerate} !== verdict_q[0]) begin
        report("verdict", {out_overlap, out_degenerate}, verdict_q[0]);
        void'(verdict_q.pop_front());
      end else void'(verdict_q.pop_front());
    end
  end

  task automatic drain();
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    if (idx < REG_HX) box_c[idx[1:0]] = val;
    else box_e[2'(idx - REG_HX)] = val[HW-1:0];
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic set_box(input coord_t cx, cy, cz, input logic [HW-1:0] hx, hy, hz);
    drain();
    write_reg(REG_CX, cx);
    write_reg(REG_CY, cy);
    write_reg(REG_CZ, cz);
    write_reg(REG_HX, {1'b0, hx});
    write_reg(REG_HY, {1'b0, hy});
    write_reg(REG_HZ, {1'b0, hz});
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_tri(input coord_t t[9]);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) @(negedge clk);
    {in_tri_a_x, in_tri_a_y, in_tri_a_z} = {t[0], t[1], t[2]};
    {in_tri_b_x, in_tri_b_y, in_tri_b_z} = {t[3], t[4], t[5]};
    {in_tri_c_x, in_tri_c_y, in_tri_c_z} = {t[6], t[7], t[8]};
    start = 1;
    do @(posedge clk); while (busy);
    verdict_q = {verdict_q, overlap_verdict(t)};
    @(negedge clk);
    start = 0;
  endtask

  function automatic coord_t near_box(input int k, input int spread);
    return coord_t'(box_c[k] + $signed($urandom_range(2*spread)) - spread);
  endfunction

  task automatic test_directed();
    coord_t t[9];
    set_box(0, 0, 0, 256, 256, 256);
    t = '{0, 0, 0, 0, 0, 0, 0, 0, 0};            send_tri(t);
    t = '{0, 0, 0, 256, 0, 0, 0, 256, 0};        send_tri(t);
    t = '{256, 0, 0, 600, 0, 0, 256, 500, 0};    send_tri(t);
    t = '{257, 0, 0, 600, 0, 0, 257, 500, 0};    send_tri(t);
    t = '{0, 0, 0, 100, 100, 100, 200, 200, 200}; send_tri(t);
    t = '{-900, 0, 900, 0, 900, 900, 900, 0, 900}; send_tri(t);
    t = '{-900, 0, 512, 900, -900, 512, 0, 900, 512}; send_tri(t);
    t = '{400, 600, 0, 600, 400, 0, 600, 600, 500}; send_tri(t);
    t = '{-8388608, -8388608, -8388608, 8388607, 8388607, -8388608,
          8388607, -8388608, 8388607};           send_tri(t);
    t = '{8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
          8388607, 8388607, 8388607};            send_tri(t);
    set_box(-8388608, 8388607, 0, 23'h7fffff, 23'h7fffff, 0);
    t = '{-8388608, 8388607, 0, 8388607, -8388608, 0, 0, 0, 0}; send_tri(t);
    t = '{0, 0, 1, 5, 0, 1, 0, 5, 1};            send_tri(t);
    t = '{0, 0, -3, 5, 0, 3, 0, 5, 0};           send_tri(t);
    set_box(8388607, -8388608, -8388608, 0, 0, 23'h7fffff);
    t = '{8388607, -8388608, 0, 8388607, -8388608, 9, 8388607, -8388608, -9};
    send_tri(t);
    t = '{8388607, -8388608, 0, 8388600, -8388600, 7, 8388607, -8388608, -9};
    send_tri(t);
  endtask

  task automatic test_random(input int count);
    coord_t t[9];
    int spread;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) begin
        spread = 1 << $urandom_range(22);
        set_box(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                HW'($urandom_range(spread)), HW'($urandom_range(spread)),
                HW'($urandom_range(spread)));
      end
      if (n == count / 2) drain();
      case ($urandom_range(9))
        0: for (int i = 0; i < 9; i++) t[i] = coord_t'($urandom);
        1: begin
          for (int i = 0; i < 3; i++) t[i] = near_box(i, spread + 16);
          for (int i = 3; i < 6; i++) t[i] = coord_t'(t[i-3] + coord_t'($urandom_range(8)) - 4);
          for (int i = 6; i < 9; i++) t[i] = coord_t'(t[i-6] + 2 * (t[i-3] - t[i-6]));
        end
        default: for (int i = 0; i < 9; i++) t[i] = near_box(i % 3, 2 * spread + 8);
      endcase
      send_tri(t);
    end
  endtask

  initial begin
    errors = 0;
    gap_pct = 15;
    rst_n = 0;
    start = 0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    {in_tri_a_x, in_tri_a_y, in_tri_a_z} = '0;
    {in_tri_b_x, in_tri_b_y, in_tri_b_z} = '0;
    {in_tri_c_x, in_tri_c_y, in_tri_c_z} = '0;
    for (int k = 0; k < 3; k++) begin
      box_c[k] = 0;
      box_e[k] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_directed();
    test_random(300);
    gap_pct = 85;
    test_random(300);
    gap_pct = 0;
    test_random(300);
    drain();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

// ===== filelist.f =====
src/tbo_pkg.sv
src/tbo_front.sv
src/tbo_prod.sv
src/tbo_back.sv
src/triangle_box_overlap_test.sv
verif/tb.sv
